// ===== rtl/core/fat12_table_engine_assert.svh =====
// Assertion macros shared by the table engine modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef FAT12_TABLE_ENGINE_ASSERT_SVH
`define FAT12_TABLE_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fte_pkg.sv =====
package fte_pkg;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 13;
  localparam int ENTRY_W  = 12;
  localparam int NUM_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 2 * BYTE_W;

  localparam logic [ENTRY_W-1:0] EOC_RESET = 12'hFFF;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = 12'hFFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_CHAIN = 2'd3
  } fte_op_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  index;
    logic [ENTRY_W-1:0]  value;
    logic [NUM_W-1:0]    entry_number;
  } fte_in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_value;
    logic               is_end;
  } fte_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_CHK,
    ST_STEP_RD,
    ST_STEP_DATA,
    ST_DONE
  } fte_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the input item, issue its first table read
    logic exec;       // finish load, read or write (table writes happen here)
    logic div_step;   // replace entry_number by its quotient by the sector size
    logic step_rd;    // issue the table read for one chain step
    logic step_data;  // take the entry of one chain step
    logic out_load;   // move the result into the output register
  } fte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    fte_op_t in_op;
    logic    chain_done;
    logic    out_busy;
  } fte_sts_t;

endpackage

// ===== rtl/core/fte_ram.sv =====
module fte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/fte_ctrl.sv =====
`include "fat12_table_engine_assert.svh"

module fte_ctrl
  import fte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output fte_cmd_t cmd,
  input  fte_sts_t sts
);

  fte_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (sts.in_op == OP_CHAIN) ? ST_DIV : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_CHK;
      end
      ST_CHK: begin
        if (sts.chain_done) begin
          if (!sts.out_busy) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_STEP_RD;
        end
      end
      ST_STEP_RD: begin
        cmd.step_rd = 1'b1;
        state_nxt   = ST_STEP_DATA;
      end
      ST_STEP_DATA: begin
        cmd.step_data = 1'b1;
        state_nxt     = ST_CHK;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `FTE_ASSERT_SAME(a_no_overwrite, cmd.out_load, !sts.out_busy, "output overwritten")
  `FTE_ASSERT_NEXT(a_acc_busy, in_valid && in_ready, state_r != ST_IDLE, "idle after accept")

endmodule

// ===== rtl/core/fte_dpath.sv =====
`include "fat12_table_engine_assert.svh"

module fte_dpath
  import fte_pkg::*;
#(
  parameter int MAX_ENTRIES    = 4096,
  parameter int SECTOR_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fte_in_t            in_data,
  input  logic               cfg_we,
  input  logic [ENTRY_W-1:0] cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output fte_out_t           out_data,
  input  fte_cmd_t           cmd,
  output fte_sts_t           sts
);

  localparam int STORE_BYTES = (3 * MAX_ENTRIES + 1) / 2;
  localparam int BANK_DEPTH  = (STORE_BYTES + 1) / 2;
  localparam int AW          = $clog2(BANK_DEPTH);
  // Division by the sector size is a multiplication by a rounded-up
  // reciprocal; with this shift it is exact for every 16-bit entry number.
  localparam int SEC_LOG     = $clog2(SECTOR_ENTRIES);
  localparam int SHIFT       = NUM_W + SEC_LOG;
  localparam int RECIP_W     = NUM_W + 2;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(SECTOR_ENTRIES) - 64'd1) / 64'(SECTOR_ENTRIES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  fte_op_t            op_r;
  logic [INDEX_W-1:0] cur_r;
  logic [ENTRY_W-1:0] val_r;
  logic [NUM_W-1:0]   dvd_r;
  logic               root_r;
  logic [ENTRY_W-1:0] eoc_r;
  logic               nodd_r;
  logic               oodd_r;
  logic               inr_r;
  logic               out_valid_r;
  fte_out_t           out_data_r;

  // Address generation: entry n sits in the 16-bit word at byte n + n/2.
  // Even bytes live in one bank, odd bytes in the other, so both bytes of
  // the word come out of a single read.
  logic [INDEX_W-1:0] a_n;
  logic [INDEX_W:0]   a_off;
  logic [INDEX_W-1:0] a_half;
  logic               a_inr;
  logic [AW-1:0]      addr_even;
  logic [AW-1:0]      addr_odd;

  assign a_n    = cmd.capture ? in_data.index : cur_r;
  assign a_off  = (INDEX_W + 1)'(a_n) + (INDEX_W + 1)'(a_n[INDEX_W-1:1]);
  assign a_half = a_off[INDEX_W:1];
  assign a_inr  = (a_n < INDEX_W'(MAX_ENTRIES)) &&
                  ((INDEX_W + 2)'(a_off) + (INDEX_W + 2)'(1) < (INDEX_W + 2)'(STORE_BYTES));
  assign addr_odd  = AW'(a_half);
  assign addr_even = a_off[0] ? AW'(a_half + INDEX_W'(1)) : AW'(a_half);

  // Table banks.
  logic              rd_en;
  logic              we_even, we_odd;
  logic [AW-1:0]     wa_even, wa_odd;
  logic [BYTE_W-1:0] wd_even, wd_odd;
  logic [BYTE_W-1:0] q_even, q_odd;

  assign rd_en = cmd.capture | cmd.step_rd;

  fte_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_bank_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (wa_even),
    .wdata (wd_even),
    .re    (rd_en),
    .raddr (addr_even),
    .rdata (q_even)
  );

  fte_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_bank_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (wa_odd),
    .wdata (wd_odd),
    .re    (rd_en),
    .raddr (addr_odd),
    .rdata (q_odd)
  );

  // Entry assembly from the registered read data.
  logic [BYTE_W-1:0]  w_lo, w_hi;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  new_word;
  logic [ENTRY_W-1:0] entry;

  assign w_lo  = oodd_r ? q_odd : q_even;
  assign w_hi  = oodd_r ? q_even : q_odd;
  assign word  = {w_hi, w_lo};
  assign entry = !inr_r ? '0 : (nodd_r ? word[WORD_W-1:WORD_W-ENTRY_W] : word[ENTRY_W-1:0]);

  // The neighbouring nibble survives a write.
  assign new_word = nodd_r ? {val_r, word[WORD_W-ENTRY_W-1:0]}
                           : {word[WORD_W-1:ENTRY_W], val_r};

  logic ld_ok;
  assign ld_ok = (INDEX_W + 1)'(cur_r) < (INDEX_W + 1)'(STORE_BYTES);

  always_comb begin
    we_even = 1'b0;
    we_odd  = 1'b0;
    wa_even = addr_even;
    wa_odd  = addr_odd;
    wd_even = oodd_r ? new_word[WORD_W-1:BYTE_W] : new_word[BYTE_W-1:0];
    wd_odd  = oodd_r ? new_word[BYTE_W-1:0] : new_word[WORD_W-1:BYTE_W];
    if (cmd.exec) begin
      case (op_r)
        OP_LOAD: begin
          wa_even = AW'(cur_r[INDEX_W-1:1]);
          wa_odd  = AW'(cur_r[INDEX_W-1:1]);
          wd_even = val_r[BYTE_W-1:0];
          wd_odd  = val_r[BYTE_W-1:0];
          we_even = ld_ok && !cur_r[0];
          we_odd  = ld_ok && cur_r[0];
        end
        OP_WRITE: begin
          we_even = inr_r;
          we_odd  = inr_r;
        end
        default: begin
          we_even = 1'b0;
          we_odd  = 1'b0;
        end
      endcase
    end
  end

  // Step count of a chain follow: entry_number divided by the sector size.
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  quot;
  logic [NUM_W-1:0]  dvd_dec;

  assign prod    = PROD_W'(dvd_r) * PROD_W'(RECIP);
  assign quot    = NUM_W'(prod >> SHIFT);
  assign dvd_dec = dvd_r - NUM_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= fte_op_t'(in_data.opcode);
      cur_r  <= in_data.index;
      val_r  <= in_data.value;
      dvd_r  <= in_data.entry_number;
      root_r <= (in_data.index == '0);
    end else if (cmd.div_step) begin
      dvd_r <= quot;
    end else if (cmd.step_data) begin
      cur_r <= INDEX_W'(entry);
      dvd_r <= dvd_dec;
    end
    if (rd_en) begin
      nodd_r <= a_n[0];
      oodd_r <= a_off[0];
      inr_r  <= a_inr;
    end
  end

  // Result selection.
  logic [ENTRY_W-1:0] res;
  logic               res_end;

  always_comb begin
    case (op_r)
      OP_READ:  res = entry;
      OP_CHAIN: begin
        if (root_r) begin
          res = (|dvd_r[NUM_W-1:ENTRY_W]) ? ENTRY_MAX : dvd_r[ENTRY_W-1:0];
        end else begin
          res = cur_r[ENTRY_W-1:0];
        end
      end
      default:  res = '0;
    endcase
  end

  assign res_end = ((op_r == OP_READ) || (op_r == OP_CHAIN)) && (res == eoc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eoc_r       <= EOC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        eoc_r <= cfg_data;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.entry_value <= res;
      out_data_r.is_end      <= res_end;
    end
  end

  logic load_exec;
  assign load_exec = cmd.exec && (op_r == OP_LOAD);

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign sts.in_op      = fte_op_t'(in_data.opcode);
  assign sts.chain_done = root_r || (dvd_r == '0);
  assign sts.out_busy   = out_valid_r && !out_ready;

  `FTE_ASSERT_SAME(a_load_one_bank, load_exec, !(we_even && we_odd), "two banks loaded")
  `FTE_ASSERT_NEXT(a_step_count, cmd.step_data, dvd_r == $past(dvd_dec), "step count stuck")

endmodule

// ===== rtl/core/fat12_table_engine.sv =====
// Channel   Ports                          Direction  Moves
// input     in_valid in_ready in_data      in         one table operation per transfer
// result    out_valid out_ready out_data   out        one result per accepted operation
// config    cfg_we cfg_data                in         end-of-chain value, no wait
//
// Load byte, read entry and write entry hold the block for one registered read of the two
// byte banks, then the write or the entry assembly, which also loads the result register
// unless the output is still stalled. A chain follow first divides entry_number by the
// sector size by a reciprocal multiplication; then each step costs a check, a registered
// table read and an entry capture, and a last check loads the result (from index 0 there
// are no steps). Reset (rst_n low, synchronous) clears the controller, the output valid
// and sets end_of_chain_value to 4095; the table itself is not cleared and holds nothing
// defined until written. A stalled result waits in the output register while the next
// transfer is accepted and worked on; that one then waits with in_ready low until the
// result side takes the stalled result.
module fat12_table_engine
  import fte_pkg::*;
#(
  parameter int MAX_ENTRIES    = 4096,
  parameter int SECTOR_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fte_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fte_out_t           out_data,
  input  logic               cfg_we,
  input  logic [ENTRY_W-1:0] cfg_data
);

  // The controller sequences each operation; the datapath owns the table
  // banks, the step-count divider, the chain cursor and the output register.
  fte_cmd_t cmd;
  fte_sts_t sts;

  fte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  fte_dpath #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .SECTOR_ENTRIES (SECTOR_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
